// ----- src/tcpq_pkg.sv -----
// Shared types and constants of the two-class priority queue.
package tcpq_pkg;

    // Default number of entries in each queue.
    localparam int QUEUE_DEPTH_DEF = 128;

    // Field widths.
    localparam int TAG_W = 16;
    localparam int KEY_W = 8;
    localparam int ENTRY_W = TAG_W + KEY_W;

    // Threshold value after reset.
    localparam logic [KEY_W-1:0] THRESHOLD_RST = 8'd60;

    // Command codes.
    typedef enum logic {
        CMD_ADD   = 1'b0,
        CMD_SERVE = 1'b1
    } command_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_ADDED_HIGH  = 3'd0,
        ST_ADDED_LOW   = 3'd1,
        ST_HIGH_FULL   = 3'd2,
        ST_LOW_FULL    = 3'd3,
        ST_SERVED_HIGH = 3'd4,
        ST_SERVED_LOW  = 3'd5,
        ST_EMPTY       = 3'd6
    } status_t;

    // One stored queue entry.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } entry_t;

    // Per-cycle operation request to one queue.
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t wr_entry;
    } ring_op_t;

    // Occupancy flags of one queue.
    typedef struct packed {
        logic full;
        logic empty;
    } ring_flags_t;

endpackage

// ----- src/tcpq_in_if.sv -----
// Request channel carrying one queue command.
interface tcpq_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [tcpq_pkg::TAG_W-1:0]   item_tag;
    logic [tcpq_pkg::KEY_W-1:0]   class_key;

    modport source (output valid, output command, output item_tag, output class_key,
                    input ready);
    modport sink (input valid, input command, input item_tag, input class_key,
                  output ready);
endinterface

// ----- src/tcpq_out_if.sv -----
// Response channel carrying one command result.
interface tcpq_out_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic [tcpq_pkg::TAG_W-1:0]   served_tag;
    logic [tcpq_pkg::KEY_W-1:0]   served_key;

    modport source (output valid, output status, output served_tag, output served_key,
                    input ready);
    modport sink (input valid, input status, input served_tag, input served_key,
                  output ready);
endinterface

// ----- src/two_class_priority_queue_top.sv -----
// Top level of the two-class strict-priority queue scheduler.
//
//   Channel   Dir   Handshake           Payload
//   req       in    valid/ready         command, item_tag, class_key
//   resp      out   valid/ready         status, served_tag, served_key
//   cfg       in    cfg_wen             cfg_wdata (priority threshold)
//
// One command is accepted per cycle unless a stalled response blocks it.
// The head and tail of each queue live in registers, so back-to-back commands
// need no interlock; stage 1 spans the memory read, before the output stage.
// Reset clears both queues and sets the threshold to 60; memory is not cleared.
// A stalled response holds the pipeline; one result and one pending command
// are held before the request side stops.
module two_class_priority_queue_top #(
    parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    tcpq_in_if.sink                    req,
    tcpq_out_if.source                 resp,
    input  logic                       cfg_wen,
    input  logic [tcpq_pkg::KEY_W-1:0] cfg_wdata
);
    import tcpq_pkg::*;

    logic [KEY_W-1:0] threshold_reg;
    ring_op_t         high_op;
    ring_op_t         low_op;
    ring_flags_t      high_flags;
    ring_flags_t      low_flags;
    entry_t           high_rd;
    entry_t           low_rd;
    entry_t           new_entry;
    logic             accept;
    logic             is_add;
    logic             to_high;
    status_t          status_next;
    logic             s1_valid_reg;
    status_t          s1_status_reg;
    logic             out_valid_reg;
    status_t          out_status_reg;
    entry_t           out_entry_reg;
    entry_t           out_entry_next;
    logic             s2_load;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_wen)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    // Pipeline flow control.
    assign s2_load   = !out_valid_reg || resp.ready;
    assign req.ready = !s1_valid_reg || s2_load;
    assign accept    = req.valid && req.ready;

    // Command decode and queue selection.
    assign is_add         = (req.command == CMD_ADD);
    assign to_high        = (req.class_key >= threshold_reg);
    assign new_entry.tag  = req.item_tag;
    assign new_entry.key  = req.class_key;

    always_comb
    begin
        high_op.push     = 1'b0;
        high_op.pop      = 1'b0;
        high_op.wr_entry = new_entry;
        low_op.push      = 1'b0;
        low_op.pop       = 1'b0;
        low_op.wr_entry  = new_entry;
        status_next      = ST_EMPTY;
        if (is_add)
        begin
            if (to_high)
            begin
                high_op.push = accept && !high_flags.full;
                status_next  = high_flags.full ? ST_HIGH_FULL : ST_ADDED_HIGH;
            end
            else
            begin
                low_op.push = accept && !low_flags.full;
                status_next = low_flags.full ? ST_LOW_FULL : ST_ADDED_LOW;
            end
        end
        else if (!high_flags.empty)
        begin
            high_op.pop = accept;
            status_next = ST_SERVED_HIGH;
        end
        else if (!low_flags.empty)
        begin
            low_op.pop  = accept;
            status_next = ST_SERVED_LOW;
        end
    end

    // The two queues.
    tcpq_ring #(.DEPTH(QUEUE_DEPTH)) u_high_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (high_op),
        .flags    (high_flags),
        .rd_entry (high_rd)
    );

    tcpq_ring #(.DEPTH(QUEUE_DEPTH)) u_low_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (low_op),
        .flags    (low_flags),
        .rd_entry (low_rd)
    );

    // Stage 1 waits for the memory read to complete.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status_next;
        end
    end

    // Select the served entry; non-serve results carry zeros.
    always_comb
    begin
        case (s1_status_reg)
            ST_SERVED_HIGH: out_entry_next = high_rd;
            ST_SERVED_LOW:  out_entry_next = low_rd;
            default:        out_entry_next = '0;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            out_status_reg <= s1_status_reg;
            out_entry_reg  <= out_entry_next;
        end
    end

    assign resp.valid      = out_valid_reg;
    assign resp.status     = out_status_reg;
    assign resp.served_tag = out_entry_reg.tag;
    assign resp.served_key = out_entry_reg.key;

endmodule

// ----- src/tcpq_ring.sv -----
// Circular FIFO ring built on a synchronous memory with a registered read.
module tcpq_ring #(
    parameter int DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcpq_pkg::ring_op_t    op,
    output tcpq_pkg::ring_flags_t flags,
    output tcpq_pkg::entry_t      rd_entry
);
    import tcpq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t            mem [DEPTH];
    entry_t            rd_entry_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;
    logic [IDX_W-1:0]  tail_reg;
    logic [IDX_W-1:0]  tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // Occupancy flags come straight from the count.
    assign flags.full  = (count_reg == FULL_CNT);
    assign flags.empty = (count_reg == '0);
    assign rd_entry    = rd_entry_reg;

    // Pointer and count update; push and pop never occur together.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (op.push)
        begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (op.pop)
        begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Memory write port at the tail.
    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            mem[tail_reg] <= op.wr_entry;
        end
    end

    // Registered memory read at the head; holds until the next pop.
    always_ff @(posedge clk)
    begin
        if (op.pop)
        begin
            rd_entry_reg <= mem[head_reg];
        end
    end

endmodule
